### design/bphr_pkg.sv
// ----------------------------------------------------------------------------
// bphr_pkg
// Shared types and constants for the button press / hold / repeat classifier.
// ----------------------------------------------------------------------------
package bphr_pkg;

    // field widths fixed by the stream format
    localparam int MASK_W      = 5;
    localparam int TIME_W      = 32;
    localparam int BTN_FIELD_W = 3;
    localparam int DEB_W       = 8;
    localparam int HOLD_W      = 16;
    localparam int REP_W       = 16;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_ADDR_W  = 2;

    // default sizes
    localparam int DEF_BUTTONS     = 5;
    localparam int DEF_QUEUE_DEPTH = 8;

    // register reset values
    localparam logic [DEB_W-1:0]  DEB_RESET  = 8'd20;
    localparam logic [HOLD_W-1:0] HOLD_RESET = 16'd1000;
    localparam logic [REP_W-1:0]  REP_RESET  = 16'd200;

    // register indexes
    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_DEBOUNCE = 2'd0,
        REG_HOLD     = 2'd1,
        REG_REPEAT   = 2'd2
    } reg_idx_t;

    // request codes carried in tuser
    typedef enum logic {
        FUNC_SAMPLE = 1'b0,
        FUNC_POP    = 1'b1
    } func_t;

    // event kinds
    typedef enum logic [1:0] {
        KIND_SHORT  = 2'd0,
        KIND_HOLD   = 2'd1,
        KIND_REPEAT = 2'd2
    } kind_t;

    // per-button phases
    typedef enum logic [2:0] {
        PH_RELEASED = 3'b001,
        PH_DEBOUNCE = 3'b010,
        PH_PRESSED  = 3'b100
    } phase_t;

    // timing configuration handed to every lane
    typedef struct packed {
        logic [DEB_W-1:0]  debounce_time;
        logic [HOLD_W-1:0] hold_time;
        logic [REP_W-1:0]  repeat_time;
    } cfg_t;

    // event found by one lane on the latest sample
    typedef struct packed {
        logic  valid;
        kind_t kind;
    } lane_evt_t;

    // one queue entry
    typedef struct packed {
        logic [BTN_FIELD_W-1:0] button;
        kind_t                  kind;
    } entry_t;

    // push request into the queue
    typedef struct packed {
        logic   valid;
        entry_t entry;
    } push_req_t;

endpackage

### design/bphr_lane.sv
// ----------------------------------------------------------------------------
// bphr_lane
// State machine of one button: debounce, short press, hold and repeat timing.
// ----------------------------------------------------------------------------
module bphr_lane
    import bphr_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              sample_en,
    input  logic              down,
    input  logic [TIME_W-1:0] now_ms,
    input  cfg_t              cfg,
    output lane_evt_t         evt
);

    phase_t            phase_reg, phase_next;
    logic [TIME_W-1:0] deb_start_reg, deb_start_next;
    logic [TIME_W-1:0] press_start_reg, press_start_next;
    logic [TIME_W-1:0] rep_start_reg, rep_start_next;
    logic              hold_sent_reg, hold_sent_next;
    lane_evt_t         evt_reg, evt_next;

    logic [TIME_W-1:0] deb_elapsed;
    logic [TIME_W-1:0] press_elapsed;
    logic [TIME_W-1:0] rep_elapsed;

    // elapsed times, modulo 2^32
    assign deb_elapsed   = now_ms - deb_start_reg;
    assign press_elapsed = now_ms - press_start_reg;
    assign rep_elapsed   = now_ms - rep_start_reg;

    // phase update on each sample
    always_comb begin
        phase_next       = phase_reg;
        deb_start_next   = deb_start_reg;
        press_start_next = press_start_reg;
        rep_start_next   = rep_start_reg;
        hold_sent_next   = hold_sent_reg;
        evt_next         = evt_reg;
        if (sample_en) begin
            evt_next.valid = 1'b0;
            evt_next.kind  = KIND_SHORT;
            case (phase_reg)
                PH_DEBOUNCE: begin
                    if (!down) begin
                        phase_next     = PH_RELEASED;
                        hold_sent_next = 1'b0;
                    end else if (deb_elapsed >= TIME_W'(cfg.debounce_time)) begin
                        press_start_next = now_ms;
                        rep_start_next   = now_ms;
                        hold_sent_next   = 1'b0;
                        phase_next       = PH_PRESSED;
                    end
                end
                PH_PRESSED: begin
                    if (!down) begin
                        if (!hold_sent_reg) begin
                            evt_next.valid = 1'b1;
                            evt_next.kind  = KIND_SHORT;
                        end
                        phase_next     = PH_RELEASED;
                        hold_sent_next = 1'b0;
                    end else if (!hold_sent_reg &&
                                 press_elapsed >= TIME_W'(cfg.hold_time)) begin
                        // hold sample skips the repeat check
                        hold_sent_next = 1'b1;
                        evt_next.valid = 1'b1;
                        evt_next.kind  = KIND_HOLD;
                    end else if (hold_sent_reg &&
                                 rep_elapsed >= TIME_W'(cfg.repeat_time)) begin
                        rep_start_next = now_ms;
                        evt_next.valid = 1'b1;
                        evt_next.kind  = KIND_REPEAT;
                    end
                end
                default: begin
                    phase_next = PH_RELEASED;
                    if (down) begin
                        deb_start_next = now_ms;
                        phase_next     = PH_DEBOUNCE;
                    end
                end
            endcase
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_RELEASED;
            hold_sent_reg <= 1'b0;
            evt_reg       <= '0;
        end else begin
            phase_reg     <= phase_next;
            hold_sent_reg <= hold_sent_next;
            evt_reg       <= evt_next;
        end
    end

    // timestamps, only read after being written
    always_ff @(posedge aclk) begin
        deb_start_reg   <= deb_start_next;
        press_start_reg <= press_start_next;
        rep_start_reg   <= rep_start_next;
    end

    assign evt = evt_reg;

endmodule

### design/bphr_queue.sv
// ----------------------------------------------------------------------------
// bphr_queue
// Ring queue of events with one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module bphr_queue
    import bphr_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  push_req_t push,
    input  logic      pop,
    output logic      rd_hit,
    output entry_t    rd_entry
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    entry_t           mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             rd_hit_reg;
    entry_t           rd_entry_reg;
    logic             do_push;
    logic             do_pop;

    // a push into a full queue is dropped
    assign do_push = push.valid && (count_reg != CNT_FULL);
    assign do_pop  = pop && (count_reg != '0);

    // pointer and count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            count_next  = count_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            count_next  = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
            rd_hit_reg <= 1'b0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
            if (pop) begin
                rd_hit_reg <= do_pop;
            end
        end
    end

    // event storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push.entry;
        end
        if (do_pop) begin
            rd_entry_reg <= mem[rd_ptr_reg];
        end
    end

    assign rd_hit   = rd_hit_reg;
    assign rd_entry = rd_entry_reg;

    // occupancy never passes the depth
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_FULL)
        else $error("queue count above depth");

    // push and pop are never requested together
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push.valid && pop))
        else $error("push and pop in the same cycle");

    // a pop from a non-empty queue takes one entry
    a_pop_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && count_reg != '0) |=> (count_reg == $past(count_reg) - CNT_W'(1)))
        else $error("pop did not decrement the count");

    // read and write pointers meet when the queue is empty
    a_ptr_meet: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0) |-> (rd_ptr_reg == wr_ptr_reg))
        else $error("empty queue with split pointers");

endmodule

### design/button_press_hold_repeat_classifier.sv
// ----------------------------------------------------------------------------
// button_press_hold_repeat_classifier
// Per-button debounce / short / hold / repeat detection with an event queue.
// ----------------------------------------------------------------------------
// One request at a time. A sample request (tuser 0): all button lanes update
// in the accept cycle, then the merge stage walks the lanes in index order,
// one per cycle, into the queue's single write port. A pop request (tuser 1):
// the queue read is registered, then the result enters the output register
// once that is free; it holds there until m_tready. A pop on an empty queue
// returns event_valid 0 with button and kind zero. Events that find the queue
// full are dropped. No clearing pass after reset.
module button_press_hold_repeat_classifier
    import bphr_pkg::*;
#(
    parameter int BUTTONS     = DEF_BUTTONS,
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration writes
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    // request channel
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [39:0]           s_tdata,   // pressed_mask[4:0], now_ms[36:5]
    input  logic                  s_tuser,   // func
    // result channel
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata,   // button[2:0], kind[4:3]
    output logic                  m_tuser    // event_valid
);

    localparam int BTN_W = (BUTTONS > 1) ? $clog2(BUTTONS) : 1;
    localparam logic [BTN_W-1:0] BTN_LAST = BTN_W'(BUTTONS - 1);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_POP  = 3'b100
    } state_t;

    state_t           state_reg, state_next;
    logic [BTN_W-1:0] scan_reg, scan_next;
    cfg_t             cfg_reg;
    logic             m_valid_reg, m_valid_next;
    logic             m_hit_reg, m_hit_next;
    entry_t           m_entry_reg, m_entry_next;

    logic              accept;
    logic              sample_en;
    logic              pop_en;
    logic              out_free;
    logic [MASK_W-1:0] mask;
    logic [TIME_W-1:0] now_ms;
    lane_evt_t         lane_evt [BUTTONS];
    lane_evt_t         cur_evt;
    push_req_t         push;
    logic              rd_hit;
    entry_t            rd_entry;

    // request decode
    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign sample_en = accept && (s_tuser == FUNC_SAMPLE);
    assign pop_en    = accept && (s_tuser == FUNC_POP);
    assign mask      = s_tdata[MASK_W-1:0];
    assign now_ms    = s_tdata[MASK_W +: TIME_W];

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.debounce_time <= DEB_RESET;
            cfg_reg.hold_time     <= HOLD_RESET;
            cfg_reg.repeat_time   <= REP_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_DEBOUNCE: cfg_reg.debounce_time <= cfg_wr_data[DEB_W-1:0];
                REG_HOLD:     cfg_reg.hold_time     <= cfg_wr_data[HOLD_W-1:0];
                REG_REPEAT:   cfg_reg.repeat_time   <= cfg_wr_data[REP_W-1:0];
                default: ;
            endcase
        end
    end

    // button lanes
    for (genvar i = 0; i < BUTTONS; i++) begin : g_lane
        logic down;
        if (i < MASK_W) begin : g_pin
            assign down = mask[i];
        end else begin : g_nopin
            assign down = 1'b0;
        end
        bphr_lane u_lane (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .sample_en (sample_en),
            .down      (down),
            .now_ms    (now_ms),
            .cfg       (cfg_reg),
            .evt       (lane_evt[i])
        );
    end

    // merge: one lane per cycle in index order
    assign cur_evt           = lane_evt[scan_reg];
    assign push.valid        = (state_reg == ST_SCAN) && cur_evt.valid;
    assign push.entry.button = BTN_FIELD_W'(scan_reg);
    assign push.entry.kind   = cur_evt.kind;

    bphr_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .pop      (pop_en),
        .rd_hit   (rd_hit),
        .rd_entry (rd_entry)
    );

    // sequencer and output register
    assign out_free = !m_valid_reg || m_tready;

    always_comb begin
        state_next   = state_reg;
        scan_next    = scan_reg;
        m_valid_next = m_valid_reg;
        m_hit_next   = m_hit_reg;
        m_entry_next = m_entry_reg;
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                scan_next = '0;
                if (sample_en) begin
                    state_next = ST_SCAN;
                end else if (pop_en) begin
                    state_next = ST_POP;
                end
            end
            ST_SCAN: begin
                if (scan_reg == BTN_LAST) begin
                    state_next = ST_IDLE;
                    scan_next  = '0;
                end else begin
                    scan_next = scan_reg + 1'b1;
                end
            end
            ST_POP: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_hit_next   = rd_hit;
                    m_entry_next = rd_hit ? rd_entry : '0;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
                scan_next  = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            scan_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            scan_reg    <= scan_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_hit_reg   <= m_hit_next;
        m_entry_reg <= m_entry_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_hit_reg;
    assign m_tdata  = {3'b000, m_entry_reg.kind, m_entry_reg.button};

endmodule
